/* rtl/vbs_pkg.sv */
// ----------------------------------------------------------------------------
// vbs_pkg
// Shared types and constants for the voice bank to single-voice stream block.
// ----------------------------------------------------------------------------
package vbs_pkg;

  localparam logic [6:0] CHUNK_LAST = 7'd127;
  localparam logic [6:0] OP_AREA    = 7'd102;
  localparam logic [4:0] OP_LAST    = 5'd16;
  localparam logic [6:0] POS_ALG    = 7'd110;
  localparam logic [6:0] POS_FBK    = 7'd111;
  localparam logic [6:0] POS_LFO    = 7'd116;

  // Operator offsets that carry packed fields.
  localparam logic [4:0] OFF_CURVE  = 5'd11;
  localparam logic [4:0] OFF_RS     = 5'd12;
  localparam logic [4:0] OFF_SENS   = 5'd13;
  localparam logic [4:0] OFF_OSC    = 5'd15;
  localparam logic [4:0] OFF_FINE   = 5'd16;

  localparam logic [2:0] HDR_LEN    = 3'd6;
  localparam logic [2:0] TAIL_LEN   = 3'd2;

  localparam logic [7:0] SYX_START  = 8'hF0;
  localparam logic [7:0] SYX_MFR    = 8'h43;
  localparam logic [7:0] SYX_ZERO   = 8'h00;
  localparam logic [7:0] SYX_FMT_HI = 8'h01;
  localparam logic [7:0] SYX_FMT_LO = 8'h1B;
  localparam logic [7:0] SYX_END    = 8'hF7;

  // How one input byte is split into parameter bytes.
  typedef enum logic [3:0] {
    K_COPY,
    K_CURVE,
    K_RS,
    K_SENS,
    K_OSC,
    K_FINE,
    K_ALG,
    K_FBK,
    K_LFO
  } kind_t;

  // One result byte plus the state updates that go with it.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       message_end;
    logic       run_last;
    logic       add_sum;
    logic       clr_sum;
    logic       load_detune;
  } vbs_res_t;

endpackage

/* rtl/vbs_decode.sv */
// ----------------------------------------------------------------------------
// vbs_decode
// Picks result byte number k of the held input byte at its chunk position.
// ----------------------------------------------------------------------------
module vbs_decode (
  input  logic [6:0]       pos,
  input  logic [4:0]       off,
  input  logic [2:0]       k,
  input  logic [6:0]       data_byte,
  input  logic [3:0]       channel,
  input  logic [3:0]       detune,
  input  logic [6:0]       sum,
  output vbs_pkg::vbs_res_t res
);

  vbs_pkg::kind_t kind;
  logic [2:0]     hdr_n;
  logic [2:0]     np;
  logic [2:0]     tail_n;
  logic [3:0]     total;
  logic [2:0]     j;
  logic [2:0]     t;
  logic [6:0]     param;

  always_comb begin
    kind = vbs_pkg::K_COPY;
    if (pos < vbs_pkg::OP_AREA) begin
      unique case (off)
        vbs_pkg::OFF_CURVE: kind = vbs_pkg::K_CURVE;
        vbs_pkg::OFF_RS:    kind = vbs_pkg::K_RS;
        vbs_pkg::OFF_SENS:  kind = vbs_pkg::K_SENS;
        vbs_pkg::OFF_OSC:   kind = vbs_pkg::K_OSC;
        vbs_pkg::OFF_FINE:  kind = vbs_pkg::K_FINE;
        default:            kind = vbs_pkg::K_COPY;
      endcase
    end else if (pos == vbs_pkg::POS_ALG) begin
      kind = vbs_pkg::K_ALG;
    end else if (pos == vbs_pkg::POS_FBK) begin
      kind = vbs_pkg::K_FBK;
    end else if (pos == vbs_pkg::POS_LFO) begin
      kind = vbs_pkg::K_LFO;
    end
  end

  always_comb begin
    unique case (kind)
      vbs_pkg::K_CURVE, vbs_pkg::K_SENS, vbs_pkg::K_OSC,
      vbs_pkg::K_FINE, vbs_pkg::K_FBK:            np = 3'd2;
      vbs_pkg::K_LFO:                             np = 3'd3;
      default:                                    np = 3'd1;
    endcase
  end

  assign hdr_n  = (pos == 7'd0) ? vbs_pkg::HDR_LEN : 3'd0;
  assign tail_n = (pos == vbs_pkg::CHUNK_LAST) ? vbs_pkg::TAIL_LEN : 3'd0;
  assign total  = {1'b0, hdr_n} + {1'b0, np} + {1'b0, tail_n};
  assign j      = k - hdr_n;
  assign t      = j - np;

  // Field j of the packed byte, by kind.
  always_comb begin
    param = data_byte;
    unique case (kind)
      vbs_pkg::K_CURVE: param = (j == 3'd0) ? {5'd0, data_byte[1:0]} : {5'd0, data_byte[3:2]};
      vbs_pkg::K_RS:    param = {4'd0, data_byte[2:0]};
      vbs_pkg::K_SENS:  param = (j == 3'd0) ? {5'd0, data_byte[1:0]} : {4'd0, data_byte[4:2]};
      vbs_pkg::K_OSC:   param = (j == 3'd0) ? {6'd0, data_byte[0]} : {2'd0, data_byte[5:1]};
      vbs_pkg::K_FINE:  param = (j == 3'd0) ? data_byte : {3'd0, detune};
      vbs_pkg::K_ALG:   param = {2'd0, data_byte[4:0]};
      vbs_pkg::K_FBK:   param = (j == 3'd0) ? {4'd0, data_byte[2:0]} : {6'd0, data_byte[3]};
      vbs_pkg::K_LFO: begin
        if (j == 3'd0) begin
          param = {6'd0, data_byte[0]};
        end else if (j == 3'd1) begin
          param = {4'd0, data_byte[3:1]};
        end else begin
          param = {4'd0, data_byte[6:4]};
        end
      end
      default:          param = data_byte;
    endcase
  end

  always_comb begin
    res             = '0;
    res.clr_sum     = (pos == 7'd0) && (k == 3'd0);
    res.run_last    = ({1'b0, k} == (total - 4'd1));
    if (k < hdr_n) begin
      unique case (k)
        3'd0:    res.out_byte = vbs_pkg::SYX_START;
        3'd1:    res.out_byte = vbs_pkg::SYX_MFR;
        3'd2:    res.out_byte = {4'h0, channel};
        3'd3:    res.out_byte = vbs_pkg::SYX_ZERO;
        3'd4:    res.out_byte = vbs_pkg::SYX_FMT_HI;
        default: res.out_byte = vbs_pkg::SYX_FMT_LO;
      endcase
    end else if (j < np) begin
      res.out_byte    = {1'b0, param};
      res.add_sum     = 1'b1;
      res.load_detune = (kind == vbs_pkg::K_RS);
    end else if (t == 3'd0) begin
      // Two's-complement checksum over the parameter bytes so far.
      res.out_byte = {1'b0, 7'd0 - sum};
    end else begin
      res.out_byte    = vbs_pkg::SYX_END;
      res.message_end = 1'b1;
    end
  end

endmodule

/* rtl/vbs_out_stage.sv */
// ----------------------------------------------------------------------------
// vbs_out_stage
// Result register of the output channel.
// ----------------------------------------------------------------------------
module vbs_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  vbs_pkg::vbs_res_t res,
  input  logic              out_ready,
  output logic              can_take,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_message_end,
  output logic              out_run_last
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       end_r;
  logic       last_r;

  assign can_take  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= res.out_byte;
      end_r  <= res.message_end;
      last_r <= res.run_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_message_end = end_r;
  assign out_run_last    = last_r;

endmodule

/* rtl/voice_bank_to_single_voice_stream.sv */
// ----------------------------------------------------------------------------
// voice_bank_to_single_voice_stream
// Turns packed bank voice bytes into single-voice system-exclusive messages.
// ----------------------------------------------------------------------------
// Each accepted input byte is held in an input register and produces one to
// seven result bytes, one per cycle while the output is not stalled, through
// the result register. The next input byte is taken in the same cycle as the
// last result of the current one. Position zero of a chunk (or any byte with
// bank_start set) opens a new message with its header, and position 127
// closes it with the checksum and the end byte.
module voice_bank_to_single_voice_stream (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [6:0]  in_data_byte,
  input  logic        in_bank_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_message_end,
  output logic        out_run_last
);

  logic [3:0]        chan_r;
  logic              hold_valid_r;
  logic [6:0]        hold_data_r;
  logic              hold_start_r;
  logic [2:0]        k_r;
  logic [6:0]        chunk_pos_r;
  logic [4:0]        op_off_r;
  logic [3:0]        detune_r;
  logic [6:0]        sum_r;
  logic [6:0]        pos;
  logic [4:0]        off;
  logic              can_take;
  logic              fire;
  logic              in_xfer;
  vbs_pkg::vbs_res_t res;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = {28'd0, chan_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= 4'd0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      chan_r <= pwdata[3:0];
    end
  end

  // Position of the held byte; bank_start forces a new chunk.
  assign pos = hold_start_r ? 7'd0 : chunk_pos_r;
  assign off = hold_start_r ? 5'd0 : op_off_r;

  vbs_decode u_decode (
    .pos       (pos),
    .off       (off),
    .k         (k_r),
    .data_byte (hold_data_r),
    .channel   (chan_r),
    .detune    (detune_r),
    .sum       (sum_r),
    .res       (res)
  );

  assign fire     = hold_valid_r && can_take;
  assign in_ready = !hold_valid_r || (fire && res.run_last);
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      k_r          <= 3'd0;
      chunk_pos_r  <= 7'd0;
      op_off_r     <= 5'd0;
      detune_r     <= 4'd0;
      sum_r        <= 7'd0;
    end else begin
      if (in_xfer) begin
        hold_valid_r <= 1'b1;
      end else if (fire && res.run_last) begin
        hold_valid_r <= 1'b0;
      end
      if (fire) begin
        k_r <= res.run_last ? 3'd0 : (k_r + 3'd1);
        if (res.clr_sum) begin
          sum_r <= 7'd0;
        end else if (res.add_sum) begin
          sum_r <= sum_r + res.out_byte[6:0];
        end
        if (res.load_detune) begin
          detune_r <= hold_data_r[6:3];
        end
        if (res.run_last) begin
          chunk_pos_r <= pos + 7'd1;
          op_off_r    <= ((pos == vbs_pkg::CHUNK_LAST) || (off == vbs_pkg::OP_LAST)) ?
                         5'd0 : (off + 5'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold_data_r  <= in_data_byte;
      hold_start_r <= in_bank_start;
    end
  end

  vbs_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (fire),
    .res             (res),
    .out_ready       (out_ready),
    .can_take        (can_take),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_message_end (out_message_end),
    .out_run_last    (out_run_last)
  );

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= 3'd6)
    else $error("result index past the longest run");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_end |-> out_run_last && (out_byte == vbs_pkg::SYX_END))
    else $error("end byte is not the closing transfer of its input");

  a_ready_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r && in_ready |-> fire && res.run_last)
    else $error("input taken while the held byte has results left");

  a_start_header: assert property (@(posedge clk) disable iff (!rst_n)
    fire && hold_start_r && (k_r == 3'd0) |=> out_byte == vbs_pkg::SYX_START)
    else $error("new chunk did not open with a header");

  a_param_7bit: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.add_sum |-> res.out_byte[7] == 1'b0)
    else $error("parameter byte wider than seven bits");

endmodule

/* verif/voice_bank_to_single_voice_stream_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_bank_to_single_voice_stream_test
// Self-checking test of the packed bank to single-voice message converter.
// Bank bytes go in through a bursty valid/ready sender while the result side
// stalls on patterns of its own. A scoreboard predicts every message byte
// (header, unpacked parameters, held detune, checksum and end byte) and checks
// each result transfer in order. The channel register is rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module voice_bank_to_single_voice_stream_test;

  localparam int         OPER_LEN     = vbs_pkg::OP_LAST + 1;
  localparam logic [2:0] CHANNEL_ADDR = 3'd0;
  localparam int         STALL_LIMIT  = 3000;
  localparam int         LONG_HOLD    = 400;
  localparam int         HOLD_AFTER   = 200;
  localparam int         MAX_PRINTS   = 40;

  typedef struct packed {
    logic [7:0] val;
    logic       fin;
    logic       last;
  } msg_byte_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE
  } rx_mode_t;

  // Predicts the message bytes caused by each accepted bank byte and checks
  // the result transfers against them in order.
  class sysex_scoreboard;
    logic [3:0] channel;
    logic [6:0] position;
    logic [3:0] detune;
    logic [6:0] sum;
    msg_byte_t  pending_bytes[$];
    logic [7:0] run_val[7];
    logic       run_fin[7];
    int         run_len;
    int         errors;
    int         seen;

    function new();
      channel  = 4'd0;
      position = 7'd0;
      detune   = 4'd0;
      sum      = 7'd0;
      run_len  = 0;
      errors   = 0;
      seen     = 0;
    endfunction

    function void set_channel(logic [3:0] c);
      channel = c;
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTS) begin
        $display("ERROR at %0t: %s", $time, msg);
      end
      errors++;
    endtask

    function void emit(logic [7:0] v, logic f);
      run_val[run_len] = v;
      run_fin[run_len] = f;
      run_len++;
    endfunction

    function void emit_param(logic [6:0] v);
      sum = sum + v;
      emit({1'b0, v}, 1'b0);
    endfunction

    function void note_voice_byte(logic [6:0] d, logic s);
      logic [6:0] pos;
      int         off;
      msg_byte_t  m;
      run_len = 0;
      if (s) begin
        position = 7'd0;
      end
      pos = position;
      if (pos == 7'd0) begin
        sum = 7'd0;
        emit(vbs_pkg::SYX_START, 1'b0);
        emit(vbs_pkg::SYX_MFR, 1'b0);
        emit({4'h0, channel}, 1'b0);
        emit(vbs_pkg::SYX_ZERO, 1'b0);
        emit(vbs_pkg::SYX_FMT_HI, 1'b0);
        emit(vbs_pkg::SYX_FMT_LO, 1'b0);
      end
      if (pos < vbs_pkg::OP_AREA) begin
        off = pos % OPER_LEN;
        case (off)
          vbs_pkg::OFF_CURVE: begin
            emit_param(7'(d[1:0]));
            emit_param(7'(d[3:2]));
          end
          vbs_pkg::OFF_RS: begin
            emit_param(7'(d[2:0]));
            detune = d[6:3];
          end
          vbs_pkg::OFF_SENS: begin
            emit_param(7'(d[1:0]));
            emit_param(7'(d[4:2]));
          end
          vbs_pkg::OFF_OSC: begin
            emit_param(7'(d[0]));
            emit_param(7'(d[5:1]));
          end
          vbs_pkg::OFF_FINE: begin
            emit_param(d);
            emit_param(7'(detune));
          end
          default: begin
            emit_param(d);
          end
        endcase
      end else if (pos == vbs_pkg::POS_ALG) begin
        emit_param(7'(d[4:0]));
      end else if (pos == vbs_pkg::POS_FBK) begin
        emit_param(7'(d[2:0]));
        emit_param(7'(d[3]));
      end else if (pos == vbs_pkg::POS_LFO) begin
        emit_param(7'(d[0]));
        emit_param(7'(d[3:1]));
        emit_param(7'(d[6:4]));
      end else begin
        emit_param(d);
      end
      if (pos == vbs_pkg::CHUNK_LAST) begin
        // The checksum is the 7-bit two's complement of the parameter sum.
        emit({1'b0, 7'(7'd0 - sum)}, 1'b0);
        emit(vbs_pkg::SYX_END, 1'b1);
      end
      for (int i = 0; i < run_len; i++) begin
        m.val  = run_val[i];
        m.fin  = run_fin[i];
        m.last = (i == run_len - 1);
        pending_bytes = {pending_bytes, m};
      end
      position = pos + 7'd1;
    endfunction

    task check_out_byte(logic [7:0] v, logic f, logic l);
      msg_byte_t e;
      seen++;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("result byte %02h arrived with nothing pending", v));
        return;
      end
      e = pending_bytes.pop_front();
      if (v !== e.val) begin
        report_mismatch($sformatf("out_byte %02h, predicted %02h", v, e.val));
      end
      if (f !== e.fin) begin
        report_mismatch($sformatf("out_message_end %b, predicted %b (byte %02h)", f, e.fin,
                                  e.val));
      end
      if (l !== e.last) begin
        report_mismatch($sformatf("out_run_last %b, predicted %b (byte %02h)", l, e.last,
                                  e.val));
      end
    endtask

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [6:0]  in_data_byte;
  logic        in_bank_start;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_message_end;
  logic        out_run_last;

  sysex_scoreboard sb;
  int              burst_left;
  int              idle_cycles;

  voice_bank_to_single_voice_stream u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_bank_start   (in_bank_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_message_end (out_message_end),
    .out_run_last    (out_run_last)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Bank byte with a bias toward the extremes of the field.
  function automatic logic [6:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic write_channel(input logic [3:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CHANNEL_ADDR;
    pwdata  <= {28'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_channel(value);
  endtask

  // Offers one bank byte; a random gap, possibly none, opens each new burst.
  task automatic send_voice_byte(input logic [6:0] d, input logic s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_data_byte  <= d;
    in_bank_start <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_voice_byte(d, s);
  endtask

  // Every byte causes at least one result, so an empty queue means idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    sb            = new();
    burst_left    = 0;
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_bank_start = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one operator's worth of bytes covers every packed operator field,
    // then new-bank starts cut the message short twice in a row.
    write_channel(4'd15);
    send_voice_byte(7'd127, 1'b1);
    send_voice_byte(7'd0, 1'b0);
    for (int i = 2; i < vbs_pkg::OFF_CURVE; i++) begin
      send_voice_byte((i % 2 == 0) ? 7'h55 : 7'h2A, 1'b0);
    end
    send_voice_byte(7'h0E, 1'b0);
    send_voice_byte(7'h7D, 1'b0);
    send_voice_byte(7'h1E, 1'b0);
    send_voice_byte(7'h40, 1'b0);
    send_voice_byte(7'h3F, 1'b0);
    send_voice_byte(7'h63, 1'b0);
    send_voice_byte(7'd0, 1'b1);
    send_voice_byte(7'd127, 1'b1);
    send_voice_byte(7'd0, 1'b0);
    wait_drained();

    // A full voice chunk with random content, then wrap into the next one.
    write_channel(4'd0);
    send_voice_byte(pick_byte(), 1'b1);
    for (int i = 1; i < 148; i++) begin
      send_voice_byte(pick_byte(), 1'b0);
    end
    wait_drained();

    // Noise: frequent new-bank starts at random points.
    write_channel(4'($urandom_range(1, 14)));
    for (int i = 0; i < 15; i++) begin
      send_voice_byte(pick_byte(), ($urandom_range(0, 3) == 0));
    end
    wait_drained();
    repeat (20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: stall patterns are redrawn at random, and once the
  // receiver holds off long enough for the block to back up into its input.
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    bit       held;
    out_ready = 1'b0;
    mode      = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held && sb.seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_out_byte(out_byte, out_message_end, out_run_last);
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  initial begin
    idle_cycles = 0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* sim.f */
rtl/vbs_pkg.sv
rtl/vbs_decode.sv
rtl/vbs_out_stage.sv
rtl/voice_bank_to_single_voice_stream.sv
verif/voice_bank_to_single_voice_stream_test.sv
